FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: src/glcc_pkg.sv
// shared types and codes for the line clearance checker
// no dependencies
`default_nettype none
package glcc_pkg;
  localparam logic [1:0] MODE_WR_OCC = 2'd0;
  localparam logic [1:0] MODE_WR_CLR = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic       CFG_OCC_MIN = 1'b0;
  localparam logic       CFG_CLR_MIN = 1'b1;
  localparam logic [7:0] OCC_MIN_RESET = 8'd130;

  // operation kind after classification
  typedef enum logic [1:0] {
    OP_WR_OCC = 2'd0,
    OP_WR_CLR = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;
endpackage
`default_nettype wire

FILE: src/glcc_front.sv
// front end: classifies items and queues them for the walker
// depends on glcc_pkg
`default_nettype none
module glcc_front #(
  parameter int COORD_BITS     = 8,
  parameter int CLEARANCE_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_mode,
  input  wire logic [COORD_BITS-1:0]     in_sx,
  input  wire logic [COORD_BITS-1:0]     in_sy,
  input  wire logic [COORD_BITS-1:0]     in_ex,
  input  wire logic [COORD_BITS-1:0]     in_ey,
  input  wire logic [15:0]               in_val,
  input  wire logic                      q_pop,
  output logic                           q_valid,
  output glcc_pkg::op_t                  q_op,
  output logic [COORD_BITS-1:0]          q_sx,
  output logic [COORD_BITS-1:0]          q_sy,
  output logic [COORD_BITS-1:0]          q_ex,
  output logic [COORD_BITS-1:0]          q_ey,
  output logic [CLEARANCE_BITS-1:0]      q_val
);
  localparam int VW = (CLEARANCE_BITS < 16) ? CLEARANCE_BITS : 16;

  // two-entry queue
  glcc_pkg::op_t               op_r [2];
  logic [COORD_BITS-1:0]       sx_r [2], sy_r [2], ex_r [2], ey_r [2];
  logic [CLEARANCE_BITS-1:0]   val_r [2];
  logic                        wp_r, rp_r;
  logic [1:0]                  cnt_r;
  logic                        push_ok, keep, pop_ok;
  glcc_pkg::op_t               op_in;
  logic [CLEARANCE_BITS-1:0]   val_in;

  // classify the incoming mode, mode 3 is dropped
  always_comb begin
    op_in = glcc_pkg::OP_QUERY;
    keep  = 1'b1;
    unique case (in_mode)
      glcc_pkg::MODE_WR_OCC: op_in = glcc_pkg::OP_WR_OCC;
      glcc_pkg::MODE_WR_CLR: op_in = glcc_pkg::OP_WR_CLR;
      glcc_pkg::MODE_QUERY:  op_in = glcc_pkg::OP_QUERY;
      default:               keep  = 1'b0;
    endcase
    val_in = '0;
    val_in[VW-1:0] = in_val[VW-1:0];
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full && keep;
  assign pop_ok  = q_pop && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_op  = op_r[rp_r];
  assign q_sx  = sx_r[rp_r];
  assign q_sy  = sy_r[rp_r];
  assign q_ex  = ex_r[rp_r];
  assign q_ey  = ey_r[rp_r];
  assign q_val = val_r[rp_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      op_r[wp_r] <= op_in;
      sx_r[wp_r] <= in_sx; sy_r[wp_r] <= in_sy;
      ex_r[wp_r] <= in_ex; ey_r[wp_r] <= in_ey;
      val_r[wp_r] <= val_in;
    end
  end
endmodule
`default_nettype wire

FILE: src/glcc_back.sv
// back end: grid memories and the line walker
// depends on glcc_pkg
`default_nettype none
module glcc_back #(
  parameter int COORD_BITS     = 8,
  parameter int CLEARANCE_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [7:0]                occ_min,
  input  wire logic [CLEARANCE_BITS-1:0] clr_min,
  input  wire logic                      q_valid,
  output logic                           q_pop,
  input  wire glcc_pkg::op_t             q_op,
  input  wire logic [COORD_BITS-1:0]     q_sx,
  input  wire logic [COORD_BITS-1:0]     q_sy,
  input  wire logic [COORD_BITS-1:0]     q_ex,
  input  wire logic [COORD_BITS-1:0]     q_ey,
  input  wire logic [CLEARANCE_BITS-1:0] q_val,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic                           out_line_clear
);
  localparam int CB    = COORD_BITS;
  localparam int AW    = 2 * COORD_BITS;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CHECK, ST_DONE} state_t;

  logic [7:0]                occ_mem [DEPTH];
  logic [CLEARANCE_BITS-1:0] clr_mem [DEPTH];
  logic [7:0]                occ_rd_r;
  logic [CLEARANCE_BITS-1:0] clr_rd_r;

  state_t           state_r;
  logic             ymaj_r;          // walk steps along y
  logic [CB-1:0]    maj_r, min_r;    // current coordinates
  logic [CB:0]      cnt_r;           // steps left
  logic [CB:0]      dmaj_r;          // major delta, positive
  logic [CB:0]      dmin_r;          // minor delta magnitude
  logic             neg_r;           // minor steps downwards
  logic [CB+1:0]    err_r;           // fractional accumulator, below dmaj
  logic             clear_r;
  logic             res_valid_r, res_r;

  logic signed [CB+1:0] dx, dy;
  logic [CB:0]      adx, ady;
  logic             sel_ymaj, swap;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic [CB+1:0]    err_add;
  logic             err_wrap;
  logic             cell_ok;
  logic             res_load;

  // endpoint deltas and walk direction
  always_comb begin
    dx  = $signed({2'b00, q_ex}) - $signed({2'b00, q_sx});
    dy  = $signed({2'b00, q_ey}) - $signed({2'b00, q_sy});
    adx = dx[CB+1] ? (CB+1)'(0) - dx[CB:0] : dx[CB:0];
    ady = dy[CB+1] ? (CB+1)'(0) - dy[CB:0] : dy[CB:0];
    sel_ymaj = !(adx > ady);
    swap = sel_ymaj ? dy[CB+1] : dx[CB+1];
  end

  // accumulator update, minor advances by whole steps plus fraction
  always_comb begin
    err_add  = err_r + {1'b0, dmin_r};
    err_wrap = (err_add >= {1'b0, dmaj_r});
  end

  assign rd_addr = ymaj_r ? {min_r, maj_r} : {maj_r, min_r};
  assign rd_en   = (state_r == ST_READ);
  assign cell_ok = !(occ_rd_r < occ_min) && !(clr_rd_r < clr_min);
  assign q_pop   = q_valid && (state_r == ST_IDLE);
  assign res_load = (state_r == ST_DONE) && (!res_valid_r || out_pop);
  assign out_empty      = !res_valid_r;
  assign out_line_clear = res_r;

  // grid memories: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (q_pop && q_op == glcc_pkg::OP_WR_OCC) occ_mem[{q_sx, q_sy}] <= q_val[7:0];
    if (q_pop && q_op == glcc_pkg::OP_WR_CLR) clr_mem[{q_sx, q_sy}] <= q_val;
    if (rd_en) begin
      occ_rd_r <= occ_mem[rd_addr];
      clr_rd_r <= clr_mem[rd_addr];
    end
  end

  // walker sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (res_load) res_valid_r <= 1'b1;
      else if (out_pop && res_valid_r) res_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && q_op == glcc_pkg::OP_QUERY) begin
            ymaj_r <= sel_ymaj;
            clear_r <= 1'b1;
            err_r  <= '0;
            if (sel_ymaj) begin
              maj_r <= swap ? q_ey : q_sy;
              min_r <= swap ? q_ex : q_sx;
              dmaj_r <= ady; dmin_r <= adx;
              neg_r <= swap ? !dx[CB+1] && (dx != 0) : dx[CB+1];
              cnt_r <= ady;
            end else begin
              maj_r <= swap ? q_ex : q_sx;
              min_r <= swap ? q_ey : q_sy;
              dmaj_r <= adx; dmin_r <= ady;
              neg_r <= swap ? !dy[CB+1] && (dy != 0) : dy[CB+1];
              cnt_r <= adx;
            end
            state_r <= (sel_ymaj ? (ady == 0) : (adx == 0)) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: state_r <= ST_CHECK;
        ST_CHECK: begin
          // floor semantics: downward steps move the minor on a nonzero fraction
          maj_r <= maj_r + CB'(1);
          cnt_r <= cnt_r - 1'b1;
          if (neg_r) begin
            if (err_r == 0 && dmin_r != 0) begin
              min_r <= min_r - CB'(1);
              err_r <= {1'b0, dmaj_r} - {1'b0, dmin_r};
            end else if (err_r >= {1'b0, dmin_r}) begin
              err_r <= err_r - {1'b0, dmin_r};
            end else begin
              min_r <= min_r - CB'(1);
              err_r <= err_r + {1'b0, dmaj_r} - {1'b0, dmin_r};
            end
          end else if (err_wrap) begin
            min_r <= min_r + CB'(1);
            err_r <= err_add - {1'b0, dmaj_r};
          end else begin
            err_r <= err_add;
          end
          if (!cell_ok) begin
            clear_r <= 1'b0;
            state_r <= ST_DONE;
          end else if (cnt_r == 1) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_READ;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            res_r <= clear_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/grid_line_clearance_check_unit.sv
// top level of the line clearance checker
// depends on glcc_pkg, glcc_front, glcc_back and assert_macros.svh
//
// usage: items go in through a queue interface (in_push / in_full), one
// transfer per item. mode 0 writes an occupancy cell, mode 1 a clearance
// cell, mode 2 queries a line; mode 3 is dropped. only queries give a
// result, seen on out_line_clear while out_empty is low, taken by out_pop.
// writes are applied when the back end pops them. a query visits the cells
// along the major axis in turn, each with one memory read (ST_READ) and
// one check (ST_CHECK), after a start in ST_IDLE, then posts the result
// from ST_DONE; the grid memories have a single read port.
// the two-entry queue between front and back accepts up to two items while
// a query walks. a blocking cell ends the walk early.
// reset clears the queues and restores occupancy_min to 130 and
// clearance_min to 0; grid contents are undefined until written.
// when the receiver stalls, one result is held and the walker waits
// with the next result; the front queue then fills and in_full rises.
// cfg writes are taken at any edge with cfg_we high and rst_n high.
`default_nettype none
`include "assert_macros.svh"
module grid_line_clearance_check_unit #(
  parameter int COORD_BITS     = 8,
  parameter int CLEARANCE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [1:0]            in_mode,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  input  wire logic [15:0]           in_cell_value,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_line_clear,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_wdata
);
  localparam int CW = (CLEARANCE_BITS < 16) ? CLEARANCE_BITS : 16;

  logic [7:0]                occ_min_r;
  logic [CLEARANCE_BITS-1:0] clr_min_r;
  logic                      q_valid, q_pop;
  glcc_pkg::op_t             q_op;
  logic [COORD_BITS-1:0]     q_sx, q_sy, q_ex, q_ey;
  logic [CLEARANCE_BITS-1:0] q_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_min_r <= glcc_pkg::OCC_MIN_RESET;
      clr_min_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == glcc_pkg::CFG_OCC_MIN) occ_min_r <= cfg_wdata[7:0];
      if (cfg_index == glcc_pkg::CFG_CLR_MIN)
        clr_min_r <= CLEARANCE_BITS'(cfg_wdata[CW-1:0]);
    end
  end

  glcc_front #(.COORD_BITS(COORD_BITS), .CLEARANCE_BITS(CLEARANCE_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_mode,
    .in_sx(in_start_x), .in_sy(in_start_y), .in_ex(in_end_x), .in_ey(in_end_y),
    .in_val(in_cell_value), .q_pop, .q_valid, .q_op, .q_sx, .q_sy, .q_ex, .q_ey,
    .q_val
  );

  glcc_back #(.COORD_BITS(COORD_BITS), .CLEARANCE_BITS(CLEARANCE_BITS)) u_back (
    .clk, .rst_n, .occ_min(occ_min_r), .clr_min(clr_min_r), .q_valid, .q_pop,
    .q_op, .q_sx, .q_sy, .q_ex, .q_ey, .q_val, .out_empty, .out_pop,
    .out_line_clear
  );

  // a held result stays put until popped
  `CHK_NEXT(a_res_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_line_clear))
  // the back end only pulls from a non-empty queue
  `CHK_IMPL(a_pop_valid, clk, rst_n, q_pop, q_valid)
endmodule
`default_nettype wire
